>>> hw/rtl/tpsb_pkg.sv
package tpsb_pkg;

  localparam int COORD_W     = 16;
  localparam int DIFF_W      = 17;
  localparam int PROD_W      = 34;
  localparam int CROSS_W     = 35;
  localparam int ABS_W       = 34;
  localparam int MSB_W       = 6;
  localparam int A_W         = 30;
  localparam int A_MSB       = 29;
  localparam int SQ_W        = 62;
  localparam int MAG_W       = 31;
  localparam int REM_W       = 63;
  localparam int SQRT_STAGES = 31;
  localparam int OUT_W       = 17;

  localparam logic [15:0] GRID_HALF      = 16'h2000;
  localparam logic [9:0]  CELL_MARGIN    = 10'd50;
  localparam logic [9:0]  CELL_HI_MARGIN = 10'd974;
  localparam logic [5:0]  GRID_LAST      = 6'd15;
  localparam logic signed [OUT_W-1:0] Y_PAD = 17'sd5;

  typedef enum logic [1:0] {
    CLS_FLOOR,
    CLS_CEIL,
    CLS_WALL,
    CLS_DEGEN
  } surf_class_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
  } vtx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1, y1, z1;
    logic signed [OUT_W-1:0]   low_y, high_y;
    logic [4:0]                cxf;
    logic [3:0]                cxl;
    logic [4:0]                czf;
    logic [3:0]                czl;
  } vtx_side_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } sgn_side_t;

  // packed so that norm_x lands in the low bits of tdata
  typedef struct packed {
    logic [3:0]                czl;
    logic [4:0]                czf;
    logic [3:0]                cxl;
    logic [4:0]                cxf;
    logic                      xp;
    surf_class_t               cls;
    logic signed [OUT_W-1:0]   high_y;
    logic signed [OUT_W-1:0]   low_y;
    logic signed [OUT_W-1:0]   offset;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nx;
  } res_t;

  function automatic logic [15:0] grid_pos(logic signed [COORD_W-1:0] c);
    logic [15:0] t;
    begin
      t = 16'(c) + GRID_HALF;
      if (t[15]) t = 16'd0;
      return t;
    end
  endfunction

  function automatic logic [4:0] first_cell(logic signed [COORD_W-1:0] c);
    logic [15:0] t;
    logic [4:0]  idx;
    begin
      t   = grid_pos(c);
      idx = t[14:10];
      if (t[9:0] < CELL_MARGIN && idx != 5'd0) idx = idx - 5'd1;
      return idx;
    end
  endfunction

  function automatic logic [3:0] last_cell(logic signed [COORD_W-1:0] c);
    logic [15:0] t;
    logic [5:0]  idx;
    begin
      t   = grid_pos(c);
      idx = {1'b0, t[14:10]};
      if (t[9:0] > CELL_HI_MARGIN) idx = idx + 6'd1;
      if (idx > GRID_LAST) idx = GRID_LAST;
      return idx[3:0];
    end
  endfunction

  function automatic logic signed [COORD_W-1:0] min3(logic signed [COORD_W-1:0] a,
                                                     logic signed [COORD_W-1:0] b,
                                                     logic signed [COORD_W-1:0] c);
    logic signed [COORD_W-1:0] m;
    begin
      m = a;
      if (b < m) m = b;
      if (c < m) m = c;
      return m;
    end
  endfunction

  function automatic logic signed [COORD_W-1:0] max3(logic signed [COORD_W-1:0] a,
                                                     logic signed [COORD_W-1:0] b,
                                                     logic signed [COORD_W-1:0] c);
    logic signed [COORD_W-1:0] m;
    begin
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      return m;
    end
  endfunction

endpackage

>>> hw/rtl/tpsb_cross.sv
module tpsb_cross (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  tpsb_pkg::vtx_t                      vtx,
  output logic                                out_valid,
  output logic [2:0][tpsb_pkg::ABS_W-1:0]     abs_c,
  output tpsb_pkg::sgn_side_t                 sgn
);
  import tpsb_pkg::*;

  logic signed [DIFF_W-1:0]  d21_r [3];
  logic signed [DIFF_W-1:0]  d32_r [3];
  logic signed [PROD_W-1:0]  p_r   [6];
  logic signed [CROSS_W-1:0] c_nxt [3];
  logic [2:0][ABS_W-1:0]     abs_r;
  sgn_side_t                 sgn_r;
  logic [2:0]                v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 3'b000;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      c_nxt[j] = CROSS_W'(p_r[2*j]) - CROSS_W'(p_r[2*j+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d21_r[0] <= DIFF_W'(vtx.x2) - DIFF_W'(vtx.x1);
      d21_r[1] <= DIFF_W'(vtx.y2) - DIFF_W'(vtx.y1);
      d21_r[2] <= DIFF_W'(vtx.z2) - DIFF_W'(vtx.z1);
      d32_r[0] <= DIFF_W'(vtx.x3) - DIFF_W'(vtx.x2);
      d32_r[1] <= DIFF_W'(vtx.y3) - DIFF_W'(vtx.y2);
      d32_r[2] <= DIFF_W'(vtx.z3) - DIFF_W'(vtx.z2);
      p_r[0] <= d21_r[1] * d32_r[2];
      p_r[1] <= d21_r[2] * d32_r[1];
      p_r[2] <= d21_r[2] * d32_r[0];
      p_r[3] <= d21_r[0] * d32_r[2];
      p_r[4] <= d21_r[0] * d32_r[1];
      p_r[5] <= d21_r[1] * d32_r[0];
      for (int j = 0; j < 3; j++) begin
        abs_r[j]     <= c_nxt[j][CROSS_W-1] ? ABS_W'(-c_nxt[j]) : ABS_W'(c_nxt[j]);
        sgn_r.neg[j] <= c_nxt[j][CROSS_W-1];
      end
      sgn_r.degen <= (c_nxt[0] == '0) && (c_nxt[1] == '0) && (c_nxt[2] == '0);
    end
  end

  assign out_valid = v_r[2];
  assign abs_c     = abs_r;
  assign sgn       = sgn_r;

endmodule

>>> hw/rtl/tpsb_norm.sv
module tpsb_norm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [2:0][tpsb_pkg::ABS_W-1:0] abs_c,
  output logic                            out_valid,
  output logic [2:0][tpsb_pkg::A_W-1:0]   ash,
  output logic [tpsb_pkg::SQ_W-1:0]       sumsq
);
  import tpsb_pkg::*;

  logic [ABS_W-1:0]        m;
  logic [MSB_W-1:0]        msb;
  logic [2:0][ABS_W-1:0]   a1_r;
  logic [MSB_W-1:0]        msb_r;
  logic [2:0][A_W-1:0]     sh_nxt;
  logic [2:0][A_W-1:0]     a2_r, a3_r, a4_r;
  logic [2:0][2*A_W-1:0]   sq_r;
  logic [SQ_W-1:0]         sum_r;
  logic [3:0]              v_r;

  // common scale puts the largest component's top bit at A_MSB
  always_comb begin
    m = abs_c[0];
    if (abs_c[1] > m) m = abs_c[1];
    if (abs_c[2] > m) m = abs_c[2];
    msb = '0;
    for (int i = 0; i < ABS_W; i++) begin
      if (m[i]) msb = MSB_W'(i);
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (msb_r >= MSB_W'(A_MSB)) begin
        sh_nxt[j] = A_W'(a1_r[j] >> (msb_r - MSB_W'(A_MSB)));
      end else begin
        sh_nxt[j] = A_W'(a1_r[j] << (MSB_W'(A_MSB) - msb_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= abs_c;
      msb_r <= msb;
      a2_r  <= sh_nxt;
      for (int j = 0; j < 3; j++) begin
        sq_r[j] <= a2_r[j] * a2_r[j];
      end
      a3_r  <= a2_r;
      sum_r <= SQ_W'(sq_r[0]) + SQ_W'(sq_r[1]) + SQ_W'(sq_r[2]);
      a4_r  <= a3_r;
    end
  end

  assign out_valid = v_r[3];
  assign ash       = a4_r;
  assign sumsq     = sum_r;

endmodule

>>> hw/rtl/tpsb_sqrt.sv
module tpsb_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [tpsb_pkg::SQ_W-1:0]     sumsq,
  input  logic [2:0][tpsb_pkg::A_W-1:0] ash_in,
  output logic                          out_valid,
  output logic [tpsb_pkg::MAG_W-1:0]    mag,
  output logic [2:0][tpsb_pkg::A_W-1:0] ash_out
);
  import tpsb_pkg::*;

  logic [REM_W-1:0]    rem_r  [SQRT_STAGES];
  logic [MAG_W-1:0]    root_r [SQRT_STAGES];
  logic [2:0][A_W-1:0] ash_r  [SQRT_STAGES];
  logic                vld_r  [SQRT_STAGES];

  // one root bit per stage, most significant first
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam int BIT = SQRT_STAGES - 1 - k;
    logic [REM_W-1:0]    prem;
    logic [MAG_W-1:0]    proot;
    logic [2:0][A_W-1:0] pash;
    logic                pv;
    logic [REM_W-1:0]    trial;

    if (k == 0) begin : g_first
      assign prem  = REM_W'(sumsq);
      assign proot = '0;
      assign pash  = ash_in;
      assign pv    = in_valid;
    end else begin : g_next
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign pash  = ash_r[k-1];
      assign pv    = vld_r[k-1];
    end

    assign trial = (REM_W'(proot) << (BIT + 1)) | (REM_W'(1) << (2 * BIT));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ash_r[k] <= pash;
        if (prem >= trial) begin
          rem_r[k]  <= prem - trial;
          root_r[k] <= proot | (MAG_W'(1) << BIT);
        end else begin
          rem_r[k]  <= prem;
          root_r[k] <= proot;
        end
      end
    end
  end

  assign out_valid = vld_r[SQRT_STAGES-1];
  assign mag       = root_r[SQRT_STAGES-1];
  assign ash_out   = ash_r[SQRT_STAGES-1];

endmodule

>>> hw/rtl/tpsb_div.sv
module tpsb_div #(
  parameter int FRAC = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [tpsb_pkg::MAG_W-1:0]    mag,
  input  logic [2:0][tpsb_pkg::A_W-1:0] ash,
  output logic                          out_valid,
  output logic [2:0][FRAC:0]            quo
);
  import tpsb_pkg::*;

  localparam int NUM_W  = FRAC + 32;
  localparam int STAGES = FRAC + 1;

  logic [2:0][NUM_W-1:0] num0_r;
  logic [MAG_W-1:0]      mag0_r;
  logic                  v0_r;
  logic [2:0][NUM_W-1:0] rem_r  [STAGES];
  logic [2:0][FRAC:0]    q_r    [STAGES];
  logic [MAG_W-1:0]      mag_r  [STAGES];
  logic                  vld_r  [STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  // round to nearest by adding half the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        num0_r[j] <= (NUM_W'(ash[j]) << FRAC) + NUM_W'(mag >> 1);
      end
      mag0_r <= mag;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam int BIT = FRAC - k;
    logic [2:0][NUM_W-1:0] prem;
    logic [2:0][FRAC:0]    pq;
    logic [MAG_W-1:0]      pmag;
    logic                  pv;
    logic [NUM_W-1:0]      dsh;

    if (k == 0) begin : g_first
      assign prem = num0_r;
      assign pq   = '0;
      assign pmag = mag0_r;
      assign pv   = v0_r;
    end else begin : g_next
      assign prem = rem_r[k-1];
      assign pq   = q_r[k-1];
      assign pmag = mag_r[k-1];
      assign pv   = vld_r[k-1];
    end

    assign dsh = NUM_W'(pmag) << BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[k] <= pmag;
        for (int j = 0; j < 3; j++) begin
          if (prem[j] >= dsh) begin
            rem_r[k][j] <= prem[j] - dsh;
            q_r[k][j]   <= pq[j] | ((FRAC+1)'(1) << BIT);
          end else begin
            rem_r[k][j] <= prem[j];
            q_r[k][j]   <= pq[j];
          end
        end
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign quo       = q_r[STAGES-1];

endmodule

>>> hw/rtl/triangle_plane_setup_and_binning.sv
// Throughput: one triangle per cycle unless the output stalls; the 31-stage square root and the
// NORMAL_FRAC_BITS + 2 stage divider set the depth, not the rate.
// A stall at the output freezes the whole pipeline in place.
// Reset (rst_n low, synchronous) clears only the stage valid bits.
module triangle_plane_setup_and_binning #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z (16 bits each)
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // norm_x, norm_y, norm_z, plane_offset, low_y, high_y, surface_class,
  // x_projection, cell_x_first, cell_x_last, cell_z_first, cell_z_last
  output logic [119:0] out_tdata
);
  import tpsb_pkg::*;

  localparam int F  = NORMAL_FRAC_BITS;
  localparam int NW = F + 2;
  localparam int MW = NW + COORD_W;
  localparam int SW = MW + 2;
  localparam int D1 = F + 40;
  localparam int D2 = F + 37;
  localparam longint HORIZ_V = (64'sd1 << F) / 100;
  localparam longint XPROJ_V = (64'sd707 << F) / 1000;
  localparam logic signed [NW-1:0] HORIZ_L = NW'(HORIZ_V);
  localparam logic [NW-1:0]        XPROJ_L = NW'(XPROJ_V);

  logic                  en;
  logic                  in_fire;
  vtx_t                  vtx;
  vtx_side_t             vs;
  logic signed [COORD_W-1:0] ymin, ymax;
  vtx_side_t             side_q [D1];
  sgn_side_t             sgn_q  [D2];

  logic                  cr_valid;
  logic [2:0][ABS_W-1:0] cr_abs;
  sgn_side_t             cr_sgn;
  logic                  nm_valid;
  logic [2:0][A_W-1:0]   nm_ash;
  logic [SQ_W-1:0]       nm_sum;
  logic                  sq_valid;
  logic [MAG_W-1:0]      sq_mag;
  logic [2:0][A_W-1:0]   sq_ash;
  logic                  dv_valid;
  logic [2:0][F:0]       dv_quo;

  logic signed [NW-1:0]  nq [3];
  logic [NW-1:0]         abs_nx;
  surf_class_t           cls_nxt;
  logic                  xp_nxt;

  logic signed [NW-1:0]  n_r  [3];
  logic signed [MW-1:0]  pr_r [3];
  surf_class_t           cls1_r;
  logic                  xp1_r;
  logic                  degen1_r;
  vtx_side_t             side1_r;
  logic                  v1_r;

  logic signed [SW-1:0]  dsum;
  logic [SW-1:0]         ad;
  logic [SW-1:0]         qd;
  logic [SW-1:0]         off;
  res_t                  res_nxt;
  res_t                  res_r;
  logic                  out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign in_fire   = in_tvalid && en;

  always_comb begin
    vtx.x1 = $signed(in_tdata[15:0]);
    vtx.y1 = $signed(in_tdata[31:16]);
    vtx.z1 = $signed(in_tdata[47:32]);
    vtx.x2 = $signed(in_tdata[63:48]);
    vtx.y2 = $signed(in_tdata[79:64]);
    vtx.z2 = $signed(in_tdata[95:80]);
    vtx.x3 = $signed(in_tdata[111:96]);
    vtx.y3 = $signed(in_tdata[127:112]);
    vtx.z3 = $signed(in_tdata[143:128]);
  end

  // extent and grid cells need only the vertices, so they ride alongside
  always_comb begin
    ymin      = min3(vtx.y1, vtx.y2, vtx.y3);
    ymax      = max3(vtx.y1, vtx.y2, vtx.y3);
    vs.x1     = vtx.x1;
    vs.y1     = vtx.y1;
    vs.z1     = vtx.z1;
    vs.low_y  = OUT_W'(ymin) - Y_PAD;
    vs.high_y = OUT_W'(ymax) + Y_PAD;
    vs.cxf    = first_cell(min3(vtx.x1, vtx.x2, vtx.x3));
    vs.cxl    = last_cell(max3(vtx.x1, vtx.x2, vtx.x3));
    vs.czf    = first_cell(min3(vtx.z1, vtx.z2, vtx.z3));
    vs.czl    = last_cell(max3(vtx.z1, vtx.z2, vtx.z3));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= vs;
      for (int i = 1; i < D1; i++) side_q[i] <= side_q[i-1];
      sgn_q[0] <= cr_sgn;
      for (int i = 1; i < D2; i++) sgn_q[i] <= sgn_q[i-1];
    end
  end

  tpsb_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_fire),
    .vtx       (vtx),
    .out_valid (cr_valid),
    .abs_c     (cr_abs),
    .sgn       (cr_sgn)
  );

  tpsb_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cr_valid),
    .abs_c     (cr_abs),
    .out_valid (nm_valid),
    .ash       (nm_ash),
    .sumsq     (nm_sum)
  );

  tpsb_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (nm_valid),
    .sumsq     (nm_sum),
    .ash_in    (nm_ash),
    .out_valid (sq_valid),
    .mag       (sq_mag),
    .ash_out   (sq_ash)
  );

  tpsb_div #(.FRAC(F)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .mag       (sq_mag),
    .ash       (sq_ash),
    .out_valid (dv_valid),
    .quo       (dv_quo)
  );

  // signed normal, class and the dot-product terms
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nq[j] = sgn_q[D2-1].neg[j] ? -NW'(dv_quo[j]) : NW'(dv_quo[j]);
    end
    abs_nx = nq[0][NW-1] ? NW'(-nq[0]) : NW'(nq[0]);
    xp_nxt = 1'b0;
    if (nq[1] > HORIZ_L) begin
      cls_nxt = CLS_FLOOR;
    end else if (nq[1] < -HORIZ_L) begin
      cls_nxt = CLS_CEIL;
    end else begin
      cls_nxt = CLS_WALL;
      xp_nxt  = abs_nx > XPROJ_L;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= dv_valid;
      out_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) n_r[j] <= nq[j];
      pr_r[0]  <= nq[0] * side_q[D1-1].x1;
      pr_r[1]  <= nq[1] * side_q[D1-1].y1;
      pr_r[2]  <= nq[2] * side_q[D1-1].z1;
      cls1_r   <= cls_nxt;
      xp1_r    <= xp_nxt;
      degen1_r <= sgn_q[D2-1].degen;
      side1_r  <= side_q[D1-1];
    end
  end

  // offset = -round(d / 2^F), halves away from zero
  always_comb begin
    dsum = SW'(pr_r[0]) + SW'(pr_r[1]) + SW'(pr_r[2]);
    ad   = dsum[SW-1] ? SW'(-dsum) : SW'(dsum);
    qd   = (ad + (SW'(1) << (F - 1))) >> F;
    off  = dsum[SW-1] ? qd : -qd;

    res_nxt        = '0;
    res_nxt.cls    = CLS_DEGEN;
    if (!degen1_r) begin
      res_nxt.nx     = COORD_W'(n_r[0]);
      res_nxt.ny     = COORD_W'(n_r[1]);
      res_nxt.nz     = COORD_W'(n_r[2]);
      res_nxt.offset = OUT_W'(off);
      res_nxt.low_y  = side1_r.low_y;
      res_nxt.high_y = side1_r.high_y;
      res_nxt.cls    = cls1_r;
      res_nxt.xp     = xp1_r;
      res_nxt.cxf    = side1_r.cxf;
      res_nxt.cxl    = side1_r.cxl;
      res_nxt.czf    = side1_r.czf;
      res_nxt.czl    = side1_r.czl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.cls == CLS_DEGEN |->
      res_r.nx == '0 && res_r.ny == '0 && res_r.nz == '0 && res_r.offset == '0)
    else $error("degenerate triangle with nonzero plane fields");

  a_xproj_wall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.xp |-> res_r.cls == CLS_WALL)
    else $error("x projection flagged on a non-wall");

  a_y_extent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.cls != CLS_DEGEN |->
      ((OUT_W+1)'(res_r.high_y) - (OUT_W+1)'(res_r.low_y)) >= 18'sd10)
    else $error("y bounds narrower than the padding");

endmodule

>>> dv/tpsb_checker.sv
module tpsb_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [119:0] out_tdata,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tpsb_pkg::*;

  localparam int FRAC = 14;

  res_t plane_q[$];

  assign pending = plane_q.size();

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint grid_t(longint c);
    longint t;
    t = (c + 'h2000) & 'hFFFF;
    if (t >= 'h8000) t = 0;
    return t;
  endfunction

  function automatic longint lo_cell(longint c);
    longint t, idx;
    t = grid_t(c);
    idx = t / 1024;
    if (t % 1024 < 50) idx = idx - 1;
    if (idx < 0) idx = 0;
    return idx;
  endfunction

  function automatic longint hi_cell(longint c);
    longint t, idx;
    t = grid_t(c);
    idx = t / 1024;
    if (t % 1024 > 1024 - 50) idx = idx + 1;
    if (idx > 15) idx = 15;
    return idx;
  endfunction

  function automatic res_t plane_setup(vtx_t v);
    res_t r;
    longint x1, y1, z1, x2, y2, z2, x3, y3, z3, d, lo, hi, q;
    longint cr[3];
    longint n[3];
    longint unsigned a[3];
    longint unsigned m, mag, ad, qu;
    r = '0;
    x1 = v.x1; y1 = v.y1; z1 = v.z1;
    x2 = v.x2; y2 = v.y2; z2 = v.z2;
    x3 = v.x3; y3 = v.y3; z3 = v.z3;
    cr[0] = (y2 - y1) * (z3 - z2) - (z2 - z1) * (y3 - y2);
    cr[1] = (z2 - z1) * (x3 - x2) - (x2 - x1) * (z3 - z2);
    cr[2] = (x2 - x1) * (y3 - y2) - (y2 - y1) * (x3 - x2);
    m = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = cr[i] < 0 ? -cr[i] : cr[i];
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      r.cls = CLS_DEGEN;
      return r;
    end
    while (m >= (64'd1 << 30)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
    end
    mag = root_floor(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
    for (int i = 0; i < 3; i++) begin
      qu = ((a[i] << FRAC) + (mag >> 1)) / mag;
      n[i] = cr[i] < 0 ? -longint'(qu) : longint'(qu);
    end
    r.nx = n[0][15:0];
    r.ny = n[1][15:0];
    r.nz = n[2][15:0];
    d = n[0] * x1 + n[1] * y1 + n[2] * z1;
    ad = d < 0 ? -d : d;
    q = longint'((ad + (64'd1 << (FRAC - 1))) >> FRAC);
    if (d >= 0) q = -q;
    r.offset = q[16:0];
    lo = y1; if (y2 < lo) lo = y2; if (y3 < lo) lo = y3;
    hi = y1; if (y2 > hi) hi = y2; if (y3 > hi) hi = y3;
    lo = lo - 5;
    hi = hi + 5;
    r.low_y = lo[16:0];
    r.high_y = hi[16:0];
    if (n[1] > (1 << FRAC) / 100) begin
      r.cls = CLS_FLOOR;
    end else if (n[1] < -((1 << FRAC) / 100)) begin
      r.cls = CLS_CEIL;
    end else begin
      r.cls = CLS_WALL;
      r.xp = ((n[0] < 0 ? -n[0] : n[0]) > (707 * (1 << FRAC)) / 1000);
    end
    lo = x1; if (x2 < lo) lo = x2; if (x3 < lo) lo = x3;
    hi = x1; if (x2 > hi) hi = x2; if (x3 > hi) hi = x3;
    r.cxf = 5'(lo_cell(lo));
    r.cxl = 4'(hi_cell(hi));
    lo = z1; if (z2 < lo) lo = z2; if (z3 < lo) lo = z3;
    hi = z1; if (z2 > hi) hi = z2; if (z3 > hi) hi = z3;
    r.czf = 5'(lo_cell(lo));
    r.czl = 4'(hi_cell(hi));
    return r;
  endfunction

  function automatic vtx_t unpack_tri(logic [143:0] d);
    vtx_t v;
    v.x1 = d[15:0];    v.y1 = d[31:16];   v.z1 = d[47:32];
    v.x2 = d[63:48];   v.y2 = d[79:64];   v.z2 = d[95:80];
    v.x3 = d[111:96];  v.y3 = d[127:112]; v.z3 = d[143:128];
    return v;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    res_t want, got;
    if (rst_n) begin
      if (in_tvalid && in_tready) plane_q.push_back(plane_setup(unpack_tri(in_tdata)));
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata);
        if (plane_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = plane_q.pop_front();
          if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz)
            $display("%0t: normal exp %0d %0d %0d got %0d %0d %0d", $time,
                     want.nx, want.ny, want.nz, got.nx, got.ny, got.nz);
          if (got.offset !== want.offset)
            $display("%0t: offset exp %0d got %0d", $time, want.offset, got.offset);
          if (got.low_y !== want.low_y || got.high_y !== want.high_y)
            $display("%0t: y range exp %0d..%0d got %0d..%0d", $time,
                     want.low_y, want.high_y, got.low_y, got.high_y);
          if (got.cls !== want.cls || got.xp !== want.xp)
            $display("%0t: class/xproj exp %0d/%0d got %0d/%0d", $time,
                     want.cls, want.xp, got.cls, got.xp);
          if ({got.cxf, got.cxl, got.czf, got.czl} !== {want.cxf, want.cxl, want.czf, want.czl})
            $display("%0t: cells exp x %0d..%0d z %0d..%0d got x %0d..%0d z %0d..%0d",
                     $time, want.cxf, want.cxl, want.czf, want.czl,
                     got.cxf, got.cxl, got.czf, got.czl);
          if (got !== want) fail_count++;
        end
      end
    end
  end
endmodule

>>> dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [119:0] out_tdata;
  int           fail_count;
  int           pending;

  triangle_plane_setup_and_binning dut (.*);

  tpsb_checker chk (.*);

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 600)) - 16'd300;
      2: return 16'h2000 + 16'($urandom_range(0, 100)) - 16'd50 - 16'(1024 * $urandom_range(0, 16));
      3: return $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 3)) : 16'h8000 + 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 20000)) - 16'd10000;
    endcase
  endfunction

  // valid stays high across back-to-back transactions
  task automatic send_tri(logic [143:0] d);
    int idle;
    idle = $urandom_range(0, 19);
    if (idle > 0) begin
      in_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_coords(logic [15:0] c[9]);
    send_tri({c[8], c[7], c[6], c[5], c[4], c[3], c[2], c[1], c[0]});
  endtask

  // receiver stall: per result a fresh wait
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    #20ms;
    $display("triangle_plane_setup_and_binning test failed");
    $finish;
  end

  initial begin
    logic [15:0] c[9];
    int w;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // floor, ceiling, x wall, z wall
    send_coords('{0, 0, 0, 0, 0, 100, 100, 0, 0});
    send_coords('{0, 0, 0, 100, 0, 0, 0, 0, 100});
    send_coords('{0, 0, 0, 0, 100, 0, 0, 0, 100});
    send_coords('{0, 0, 0, 100, 0, 0, 0, 100, 0});
    // degenerate: all same, collinear
    send_coords('{7, 7, 7, 7, 7, 7, 7, 7, 7});
    send_coords('{0, 0, 0, 1, 2, 3, 2, 4, 6});
    // extremes with sign flips
    send_coords('{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                  16'h8000, 16'h7fff, 16'h7fff});
    send_coords('{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                  16'h7fff, 16'h8000, 16'h8000});
    send_coords('{16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000,
                  16'hffff, 16'hffff, 16'h0000});
    // grid edges and margins, wrap of the grid add
    send_coords('{16'he000, 0, 16'he000, 16'h1fff, 10, 16'he031, 16'he032, 20, 16'h1fff});
    send_coords('{16'hdfff, 0, 16'h6000, 16'h03ce, 5, 16'h03cf, 16'h2000, 9, 16'h0031});
    send_coords('{16'h6000, 0, 16'h5fff, 16'h7000, 0, 16'h7fff, 16'h6001, 3, 16'h6010});
    // ceilings with a tiny tilt
    send_coords('{0, 0, 0, 1000, 1, 0, 0, 0, 1000});
    send_coords('{0, 0, 0, 1000, 0, 0, 0, 1, 1000});
    for (int k = 0; k < 1150; k++) begin
      for (int j = 0; j < 9; j++) c[j] = rand_coord();
      if ($urandom_range(0, 19) == 0) begin
        c[6] = c[3] + (c[3] - c[0]);
        c[7] = c[4] + (c[4] - c[1]);
        c[8] = c[5] + (c[5] - c[2]);
      end
      send_coords(c);
    end
    in_tvalid <= 1'b0;
    w = 0;
    while (pending != 0 && w < 100000) begin
      @(posedge clk);
      w++;
    end
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("triangle_plane_setup_and_binning test passed");
    end else begin
      $display("triangle_plane_setup_and_binning test failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/tpsb_pkg.sv
hw/rtl/tpsb_cross.sv
hw/rtl/tpsb_norm.sv
hw/rtl/tpsb_sqrt.sv
hw/rtl/tpsb_div.sv
hw/rtl/triangle_plane_setup_and_binning.sv
dv/tpsb_checker.sv
dv/tb.sv
